### hdl/multi_pattern_first_match_core_defines.svh
// Assertion macros shared by the pattern search RTL.
// Needs clk and arst_n in the scope of each use.
`ifndef MULTI_PATTERN_FIRST_MATCH_CORE_DEFINES_SVH
`define MULTI_PATTERN_FIRST_MATCH_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define MPFM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define MPFM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/mpfm_pkg.sv
// Types, constants and helpers of the multi-pattern first-match search.
// Used by the top level, mpfm_cell and mpfm_out_buf; depends on nothing.
package mpfm_pkg;

	localparam int REG_PATTERNS        = 4;
	localparam int REG_BYTES           = 8;
	localparam int LEN_BITS            = 4;
	localparam int START_W             = 16;
	localparam int END_W               = 17;
	localparam int DATA_W              = 64;
	localparam int MAX_PATTERNS_DEF    = 4;
	localparam int MAX_PATTERN_LEN_DEF = 8;
	localparam int OFFSET_BITS_DEF     = 16;

	localparam logic [15:0] LENGTHS_RST = 16'h1111;
	localparam logic [2:0]  COUNT_RST   = 3'd1;

	typedef enum logic [2:0] {
		REG_PAT_ZERO  = 3'd0,
		REG_PAT_ONE   = 3'd1,
		REG_PAT_TWO   = 3'd2,
		REG_PAT_THREE = 3'd3,
		REG_LENGTHS   = 3'd4,
		REG_COUNT     = 3'd5
	} cfg_reg_t;

	typedef logic [REG_BYTES-1:0][7:0] pat_word_t;

	typedef struct packed {
		pat_word_t [REG_PATTERNS-1:0]               words;
		logic [REG_PATTERNS-1:0][LEN_BITS-1:0]      lens;
	} pat_cfg_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       last_byte;
	} in_beat_t;

	typedef struct packed {
		logic               found;
		logic [1:0]         pattern_index;
		logic [START_W-1:0] start_offset;
		logic [END_W-1:0]   end_offset;
	} out_beat_t;

	typedef struct packed {
		cfg_reg_t          index;
		logic [DATA_W-1:0] write_data;
	} cfg_beat_t;

	function automatic logic [LEN_BITS-1:0] clamp_len(
		input logic [LEN_BITS-1:0] raw,
		input logic [LEN_BITS-1:0] cap
	);
		logic [LEN_BITS-1:0] n;
		n = raw;
		if (n == '0) begin
			n = LEN_BITS'(1);
		end
		if (n > cap) begin
			n = cap;
		end
		return n;
	endfunction

endpackage

### hdl/mpfm_stream_if.sv
// Valid/ready channel carrying one payload beat.
// Payload types come from mpfm_pkg.
interface mpfm_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### hdl/multi_pattern_first_match_core.sv
// Top level of the multi-pattern first-match search.
// Uses mpfm_pkg, mpfm_stream_if, mpfm_cell, mpfm_out_buf and the assertion macros.
//
// Channels: text_in takes one text byte per beat, with last_byte marking the end
// of a text. result_out gives at most one beat per text: found, the pattern index,
// start offset and the offset just after the match. cfg_in writes a pattern
// register (index 0..3 bytes, 4 lengths, 5 count); cfg_in.ready is always high.
// Throughput: one byte per cycle while the skid entry is empty. A row of window
// cells shifts the text and compares every pattern in parallel; the best-match
// update and the decision to answer finish in the same cycle the byte is taken.
// Output: a result beat is registered when the byte that settles it is taken
// (the earliest match can no longer be beaten, or the last byte).
// Stall: results sit in an output register backed by one skid entry; text_in
// keeps taking bytes until the skid entry fills.
// Reset: patterns clear, lengths read 1, count is 1, search state and the
// result buffer empty. After a last byte the search state returns to reset.
`include "multi_pattern_first_match_core_defines.svh"

module multi_pattern_first_match_core #(
	parameter int MAX_PATTERNS    = mpfm_pkg::MAX_PATTERNS_DEF,
	parameter int MAX_PATTERN_LEN = mpfm_pkg::MAX_PATTERN_LEN_DEF,
	parameter int OFFSET_BITS     = mpfm_pkg::OFFSET_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	mpfm_stream_if.sink   text_in,
	mpfm_stream_if.source result_out,
	mpfm_stream_if.sink   cfg_in
);

	localparam int LenCap   = (MAX_PATTERN_LEN < mpfm_pkg::REG_BYTES) ?
		MAX_PATTERN_LEN : mpfm_pkg::REG_BYTES;
	localparam int PatLimit = (MAX_PATTERNS < mpfm_pkg::REG_PATTERNS) ?
		MAX_PATTERNS : mpfm_pkg::REG_PATTERNS;
	localparam logic [mpfm_pkg::LEN_BITS-1:0] CapLen = mpfm_pkg::LEN_BITS'(LenCap);
	localparam logic [2:0] PatLimitC = 3'(PatLimit);
	localparam logic [OFFSET_BITS-1:0] AnswerGap = OFFSET_BITS'(LenCap - 1);

	mpfm_pkg::pat_word_t [mpfm_pkg::REG_PATTERNS-1:0] words_q;
	logic [15:0]                lengths_q;
	logic [2:0]                 count_q;
	mpfm_pkg::pat_cfg_t         pat_cfg;
	logic [2:0]                 active;

	logic [OFFSET_BITS-1:0]     pos_q;
	logic                       best_valid_q;
	logic [OFFSET_BITS-1:0]     best_start_q;
	logic [1:0]                 best_pat_q;
	logic [mpfm_pkg::LEN_BITS-1:0] best_len_q;
	logic                       answered_q;

	logic                       best_valid_n;
	logic [OFFSET_BITS-1:0]     best_start_n;
	logic [1:0]                 best_pat_n;
	logic [mpfm_pkg::LEN_BITS-1:0] best_len_n;

	logic                       accept;
	logic                       last;
	logic                       emit;
	logic                       can_push;
	logic [OFFSET_BITS:0]       end_sum;
	mpfm_pkg::out_beat_t        beat;

	logic [LenCap-1:0][7:0]                        cell_byte;
	logic [LenCap-1:0][mpfm_pkg::REG_PATTERNS-1:0] cell_hit;
	logic [mpfm_pkg::REG_PATTERNS-1:0]             pat_hit;

	assign cfg_in.ready  = 1'b1;
	assign text_in.ready = can_push;
	assign accept        = text_in.valid && text_in.ready;
	assign last          = text_in.payload.last_byte;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_q   <= '0;
			lengths_q <= mpfm_pkg::LENGTHS_RST;
			count_q   <= mpfm_pkg::COUNT_RST;
		end else if (cfg_in.valid && cfg_in.ready) begin
			case (cfg_in.payload.index)
				mpfm_pkg::REG_PAT_ZERO:  words_q[0] <= cfg_in.payload.write_data;
				mpfm_pkg::REG_PAT_ONE:   words_q[1] <= cfg_in.payload.write_data;
				mpfm_pkg::REG_PAT_TWO:   words_q[2] <= cfg_in.payload.write_data;
				mpfm_pkg::REG_PAT_THREE: words_q[3] <= cfg_in.payload.write_data;
				mpfm_pkg::REG_LENGTHS:   lengths_q <= cfg_in.payload.write_data[15:0];
				mpfm_pkg::REG_COUNT:     count_q <= cfg_in.payload.write_data[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		pat_cfg.words = words_q;
		for (int k = 0; k < mpfm_pkg::REG_PATTERNS; k++) begin
			pat_cfg.lens[k] = mpfm_pkg::clamp_len(lengths_q[4*k +: 4], CapLen);
		end
		active = (count_q > PatLimitC) ? PatLimitC : count_q;
	end

	// window cells
	for (genvar j = 0; j < LenCap; j++) begin : g_cell
		mpfm_cell #(
			.CELL_IDX (j)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (accept),
			.clear   (last),
			.byte_in ((j == 0) ? text_in.payload.text_byte : cell_byte[(j == 0) ? 0 : j-1]),
			.cfg     (pat_cfg),
			.byte_q  (cell_byte[j]),
			.hit     (cell_hit[j])
		);
	end

	always_comb begin
		for (int k = 0; k < mpfm_pkg::REG_PATTERNS; k++) begin
			pat_hit[k] = 1'b1;
			for (int j = 0; j < LenCap; j++) begin
				pat_hit[k] = pat_hit[k] & cell_hit[j][k];
			end
		end
	end

	// best match update and answer decision
	always_comb begin
		logic [OFFSET_BITS-1:0] gap;
		logic [OFFSET_BITS-1:0] st;
		best_valid_n = best_valid_q;
		best_start_n = best_start_q;
		best_pat_n   = best_pat_q;
		best_len_n   = best_len_q;
		for (int k = 0; k < PatLimit; k++) begin
			gap = OFFSET_BITS'(pat_cfg.lens[k] - mpfm_pkg::LEN_BITS'(1));
			st  = pos_q - gap;
			if ((3'(k) < active) && pat_hit[k] && (pos_q >= gap)) begin
				if (!best_valid_n || (st < best_start_n) ||
					((st == best_start_n) && (2'(k) < best_pat_n))) begin
					best_valid_n = 1'b1;
					best_start_n = st;
					best_pat_n   = 2'(k);
					best_len_n   = pat_cfg.lens[k];
				end
			end
		end
		emit = accept && !answered_q &&
			((best_valid_n && ((pos_q - best_start_n) >= AnswerGap)) || last);
		end_sum = {1'b0, best_start_n} + (OFFSET_BITS+1)'(best_len_n);
		if (best_valid_n) begin
			beat.found         = 1'b1;
			beat.pattern_index = best_pat_n;
			beat.start_offset  = mpfm_pkg::START_W'(best_start_n);
			beat.end_offset    = mpfm_pkg::END_W'(end_sum);
		end else begin
			beat = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			best_valid_q <= 1'b0;
			best_start_q <= '0;
			best_pat_q   <= '0;
			best_len_q   <= '0;
			answered_q   <= 1'b0;
		end else if (accept) begin
			if (last) begin
				pos_q        <= '0;
				best_valid_q <= 1'b0;
				best_start_q <= '0;
				best_pat_q   <= '0;
				best_len_q   <= '0;
				answered_q   <= 1'b0;
			end else begin
				if (!answered_q) begin
					best_valid_q <= best_valid_n;
					best_start_q <= best_start_n;
					best_pat_q   <= best_pat_n;
					best_len_q   <= best_len_n;
				end
				answered_q <= answered_q | emit;
				if (pos_q != '1) begin
					pos_q <= pos_q + OFFSET_BITS'(1);
				end
			end
		end
	end

	mpfm_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (emit),
		.beat     (beat),
		.can_push (can_push),
		.dst      (result_out)
	);

	`MPFM_ASSERT_NEXT(a_last_clears, accept && last, (pos_q == '0) && !answered_q,
		"search state not cleared after last byte")
	`MPFM_ASSERT_NOW(a_best_behind_pos, best_valid_q, best_start_q <= pos_q,
		"best match starts after current position")
	`MPFM_ASSERT_NOW(a_single_answer, answered_q && accept && !last, !emit,
		"second result for one text")
	`MPFM_ASSERT_NEXT(a_emit_shows, emit, result_out.valid, "emitted result not visible")

endmodule

### hdl/mpfm_cell.sv
// One window cell: holds one text byte and compares its incoming byte
// against the matching byte of every pattern. Uses mpfm_pkg.
module mpfm_cell #(
	parameter int CELL_IDX = 0
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   advance,
	input  logic                                   clear,
	input  logic [7:0]                             byte_in,
	input  mpfm_pkg::pat_cfg_t                     cfg,
	output logic [7:0]                             byte_q,
	output logic [mpfm_pkg::REG_PATTERNS-1:0]      hit
);

	localparam logic [mpfm_pkg::LEN_BITS-1:0] Idx = mpfm_pkg::LEN_BITS'(CELL_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (advance) begin
			if (clear) begin
				byte_q <= '0;
			end else begin
				byte_q <= byte_in;
			end
		end
	end

	always_comb begin
		logic [mpfm_pkg::LEN_BITS-1:0] pos;
		for (int k = 0; k < mpfm_pkg::REG_PATTERNS; k++) begin
			pos = cfg.lens[k] - Idx - mpfm_pkg::LEN_BITS'(1);
			hit[k] = (Idx >= cfg.lens[k]) ||
				(byte_in == cfg.words[k][pos[$clog2(mpfm_pkg::REG_BYTES)-1:0]]);
		end
	end

endmodule

### hdl/mpfm_out_buf.sv
// Two-entry result buffer (output register plus skid) on the result channel.
// Uses mpfm_pkg, mpfm_stream_if and the assertion macros.
`include "multi_pattern_first_match_core_defines.svh"

module mpfm_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  mpfm_pkg::out_beat_t beat,
	output logic                can_push,
	mpfm_stream_if.source       dst
);

	logic                out_valid_q;
	mpfm_pkg::out_beat_t out_data_q;
	logic                skid_valid_q;
	mpfm_pkg::out_beat_t skid_data_q;
	logic                take;

	assign take        = out_valid_q && dst.ready;
	assign can_push    = !skid_valid_q;
	assign dst.valid   = out_valid_q;
	assign dst.payload = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_valid_q || take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_data_q <= skid_data_q;
			end
		end else if (push) begin
			if (!out_valid_q || take) begin
				out_data_q <= beat;
			end else begin
				skid_data_q <= beat;
			end
		end
	end

	`MPFM_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q, "skid full with empty output")
	`MPFM_ASSERT_NOW(a_no_push_when_full, push, !skid_valid_q, "beat pushed into full buffer")
	`MPFM_ASSERT_NEXT(a_skid_drains, skid_valid_q && take, out_valid_q && !skid_valid_q,
		"skid beat lost on drain")

endmodule
